>>> hdl/mrm_pkg.sv
package mrm_pkg;

  // input modes
  localparam logic [2:0] ModeBegin    = 3'd0;
  localparam logic [2:0] ModeParam    = 3'd1;
  localparam logic [2:0] ModeEnd      = 3'd2;
  localparam logic [2:0] ModeRxByte   = 3'd3;
  localparam logic [2:0] ModeFrameEnd = 3'd4;

  // result kinds
  localparam logic [1:0] KindTx     = 2'd0;
  localparam logic [1:0] KindStore  = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  // status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StTimeout   = 3'd1;
  localparam logic [2:0] StBadFrame  = 3'd2;
  localparam logic [2:0] StBadCrc    = 3'd3;
  localparam logic [2:0] StInvalid   = 3'd4;
  localparam logic [2:0] StException = 3'd5;
  localparam logic [2:0] StLinkFault = 3'd6;

  localparam logic [7:0]  MaxCapacity   = 8'd252;
  localparam logic [7:0]  ExceptionMask = 8'h80;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [8:0]  MaxFrameIndex = 9'd255;

  localparam int QueueDepthDefault = 4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TX,
    PH_RX
  } phase_e;

  // work handed from front to back
  typedef enum logic [2:0] {
    CMD_TX1,
    CMD_TX2,
    CMD_TX2_TMO,
    CMD_STORE,
    CMD_STATUS
  } cmd_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] slave_address;
    logic [7:0] function_number;
    logic [7:0] data_byte;
    logic       expect_reply;
    logic       link_fault;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] store_index;
    logic [2:0] status;
    logic [7:0] exception_value;
    logic [7:0] payload_length;
    logic       last;
  } out_word_t;

  typedef struct packed {
    cmd_e       op;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] index;
    logic [2:0] status;
    logic [7:0] exc;
    logic [7:0] plen;
  } cmd_t;

  // one byte into the reflected crc-16/modbus
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/mrm_front.sv
module mrm_front import mrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  in_word_t   in_data_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       q_full_i,
  output logic       full_o,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [8:0]  count_q, count_d;
  logic [7:0]  exp_addr_q, exp_addr_d;
  logic [7:0]  exp_fn_q, exp_fn_d;
  logic        invalid_q, invalid_d;
  logic        exc_q, exc_d;
  logic [7:0]  exc_val_q, exc_val_d;
  logic        busy_q, busy_d;
  logic [7:0]  cap_q;

  logic        accept;
  logic [7:0]  cap;
  logic [8:0]  room;
  logic [15:0] crc_src;
  logic [7:0]  byte_src;
  logic [15:0] crc_out;
  logic        tx_ph;
  logic        rx_ph;
  logic        overlong;

  assign full_o   = q_full_i | busy_q;
  assign accept   = push_i & ~full_o;
  assign cap      = (cap_q > MaxCapacity) ? MaxCapacity : cap_q;
  assign room     = exc_q ? 9'd1 : {1'b0, cap};
  assign tx_ph    = (phase_q == PH_TX);
  assign rx_ph    = (phase_q == PH_RX);
  assign overlong = (count_q > MaxFrameIndex);
  assign crc_out  = crc_feed(crc_src, byte_src);

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= MaxCapacity;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // phase next state
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      priority if (in_data_i.mode == ModeBegin) begin
        phase_d = PH_TX;
      end else if (in_data_i.mode == ModeEnd && tx_ph) begin
        phase_d = in_data_i.expect_reply ? PH_RX : PH_IDLE;
      end else if (in_data_i.mode == ModeRxByte && rx_ph && overlong) begin
        phase_d = PH_IDLE;
      end else if (in_data_i.mode == ModeFrameEnd && rx_ph) begin
        phase_d = PH_IDLE;
      end else begin
        phase_d = phase_q;
      end
    end
  end

  // classification, crc and command words
  always_comb begin
    crc_d      = crc_q;
    count_d    = count_q;
    exp_addr_d = exp_addr_q;
    exp_fn_d   = exp_fn_q;
    invalid_d  = invalid_q;
    exc_d      = exc_q;
    exc_val_d  = exc_val_q;
    busy_d     = 1'b0;
    crc_src    = crc_q;
    byte_src   = in_data_i.data_byte;
    cmd_push_o = 1'b0;
    cmd_o      = '0;

    if (busy_q) begin
      // second header byte of a begin command
      byte_src = exp_fn_q;
      crc_d    = crc_out;
    end else if (accept) begin
      priority if (in_data_i.mode == ModeBegin) begin
        exp_addr_d   = in_data_i.slave_address;
        exp_fn_d     = in_data_i.function_number;
        crc_src      = CrcInit;
        byte_src     = in_data_i.slave_address;
        crc_d        = crc_out;
        busy_d       = 1'b1;
        cmd_push_o   = 1'b1;
        cmd_o.op     = CMD_TX2;
        cmd_o.byte0  = in_data_i.slave_address;
        cmd_o.byte1  = in_data_i.function_number;
      end else if (in_data_i.mode == ModeParam && tx_ph) begin
        crc_d        = crc_out;
        cmd_push_o   = 1'b1;
        cmd_o.op     = CMD_TX1;
        cmd_o.byte0  = in_data_i.data_byte;
      end else if (in_data_i.mode == ModeEnd && tx_ph) begin
        cmd_push_o   = 1'b1;
        cmd_o.op     = in_data_i.expect_reply ? CMD_TX2 : CMD_TX2_TMO;
        cmd_o.byte0  = crc_q[7:0];
        cmd_o.byte1  = crc_q[15:8];
        crc_d        = CrcInit;
        count_d      = '0;
        invalid_d    = 1'b0;
        exc_d        = 1'b0;
        exc_val_d    = '0;
      end else if (in_data_i.mode == ModeRxByte && rx_ph) begin
        crc_d   = crc_out;
        count_d = count_q + 9'd1;
        priority if (count_q == 9'd0) begin
          if (in_data_i.data_byte != exp_addr_q) begin
            invalid_d = 1'b1;
          end
        end else if (count_q == 9'd1) begin
          if (in_data_i.data_byte == (exp_fn_q | ExceptionMask)) begin
            exc_d = 1'b1;
          end else if (in_data_i.data_byte != exp_fn_q) begin
            invalid_d = 1'b1;
          end
        end else if (count_q < room + 9'd2) begin
          if (exc_q) begin
            exc_val_d = in_data_i.data_byte;
          end else begin
            cmd_push_o  = 1'b1;
            cmd_o.op    = CMD_STORE;
            cmd_o.byte0 = in_data_i.data_byte;
            cmd_o.index = 8'(count_q - 9'd2);
          end
        end else if (overlong) begin
          // frame too long: status now, count stays
          count_d      = count_q;
          cmd_push_o   = 1'b1;
          cmd_o.op     = CMD_STATUS;
          cmd_o.status = StBadFrame;
        end else if (count_q >= room + 9'd4) begin
          invalid_d = 1'b1;
        end else begin
          invalid_d = invalid_q;
        end
      end else if (in_data_i.mode == ModeFrameEnd && rx_ph) begin
        cmd_push_o = 1'b1;
        cmd_o.op   = CMD_STATUS;
        priority if (in_data_i.link_fault) begin
          cmd_o.status = StLinkFault;
        end else if (count_q == 9'd0) begin
          cmd_o.status = StTimeout;
        end else if (count_q < 9'd4) begin
          cmd_o.status = StBadFrame;
        end else if (crc_q != 16'h0000) begin
          cmd_o.status = StBadCrc;
        end else if (invalid_q || (exc_q && count_q != 9'd5)) begin
          cmd_o.status = StInvalid;
        end else if (exc_q) begin
          cmd_o.status = StException;
          cmd_o.exc    = exc_val_q;
        end else begin
          cmd_o.status = StOk;
          cmd_o.plen   = 8'(count_q - 9'd4);
        end
      end else begin
        cmd_push_o = 1'b0;
      end
    end
  end

  // front state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      crc_q      <= CrcInit;
      count_q    <= '0;
      exp_addr_q <= '0;
      exp_fn_q   <= '0;
      invalid_q  <= 1'b0;
      exc_q      <= 1'b0;
      exc_val_q  <= '0;
      busy_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      crc_q      <= crc_d;
      count_q    <= count_d;
      exp_addr_q <= exp_addr_d;
      exp_fn_q   <= exp_fn_d;
      invalid_q  <= invalid_d;
      exc_q      <= exc_d;
      exc_val_q  <= exc_val_d;
      busy_q     <= busy_d;
    end
  end

endmodule

>>> hdl/mrm_cmd_queue.sv
module mrm_cmd_queue import mrm_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> hdl/mrm_back.sv
module mrm_back import mrm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_word_t out_data_o
);

  logic [1:0] step_q, step_d;
  logic       valid_q, valid_d;
  out_word_t  out_q, word;
  logic       load;

  assign load       = ~q_empty_i & (~valid_q | pop_i);
  assign q_pop_o    = load & word.last;
  assign empty_o    = ~valid_q;
  assign out_data_o = out_q;

  // expand the head command into result words
  always_comb begin
    word = '0;
    unique case (cmd_i.op)
      CMD_TX1: begin
        word.kind     = KindTx;
        word.out_byte = cmd_i.byte0;
        word.last     = 1'b1;
      end
      CMD_TX2: begin
        word.kind     = KindTx;
        word.out_byte = (step_q == 2'd0) ? cmd_i.byte0 : cmd_i.byte1;
        word.last     = (step_q != 2'd0);
      end
      CMD_TX2_TMO: begin
        if (step_q == 2'd2) begin
          word.kind   = KindStatus;
          word.status = StTimeout;
          word.last   = 1'b1;
        end else begin
          word.kind     = KindTx;
          word.out_byte = (step_q == 2'd0) ? cmd_i.byte0 : cmd_i.byte1;
        end
      end
      CMD_STORE: begin
        word.kind        = KindStore;
        word.out_byte    = cmd_i.byte0;
        word.store_index = cmd_i.index;
        word.last        = 1'b1;
      end
      CMD_STATUS: begin
        word.kind            = KindStatus;
        word.status          = cmd_i.status;
        word.exception_value = cmd_i.exc;
        word.payload_length  = cmd_i.plen;
        word.last            = 1'b1;
      end
      default: begin
        word = '0;
      end
    endcase
  end

  // step and output valid
  always_comb begin
    step_d  = step_q;
    valid_d = valid_q;
    if (load) begin
      step_d  = word.last ? 2'd0 : step_q + 2'd1;
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= word;
    end
  end

endmodule

>>> hdl/modbus_rtu_master_framer_top.sv
// Modbus RTU master framer. Write command items (begin, parameter bytes, end) to get the
// transmit bytes with the CRC-16/MODBUS low and high byte appended; then write received
// bytes and a frame-end item to get store words for the payload and one status word.
// Both sides are queues: an item is taken on push while full is low, a result word is
// taken on pop while empty is low. Items are taken one per cycle while the command queue
// has room, except that a begin command raises full for a single cycle while the single
// byte-wide CRC unit folds in the function code. Result words leave one per cycle while
// pop is high, from an output register fed by a command queue of QueueDepth entries; the
// end of a broadcast yields three words. The user must write buffer_capacity through
// cfg_we_i/cfg_wdata_i while the block is idle, unenforced; values above 252 act as 252.
module modbus_rtu_master_framer_top import mrm_pkg::*; #(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_word_t   in_data_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output logic       empty,
  input  logic       pop,
  output out_word_t  out_data_o
);

  logic cmd_push, q_full, q_empty, q_pop;
  cmd_t cmd_in, cmd_head;

  mrm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .full_o      (full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  mrm_cmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (cmd_head),
    .empty_o (q_empty)
  );

  mrm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_data_o (out_data_o)
  );

endmodule

>>> tb/tb_modbus_rtu_master_framer_top.sv
`timescale 1ns / 1ps

module tb_modbus_rtu_master_framer_top;
  import mrm_pkg::*;

  localparam int ClkPeriod    = 12;
  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 120;
  localparam int RandomItems  = 160;
  localparam int QuietItems   = 30;
  localparam int RunLimitNs   = 4_000_000;

  // modes that the block never honors
  localparam logic [2:0] ModeUnusedLo = 3'd5;
  localparam logic [2:0] ModeUnusedHi = 3'd7;

  // shapes of slave reply used by the random part
  typedef enum int {
    RspOk,
    RspException,
    RspLongExc,
    RspBadCrc,
    RspWrongAddr,
    RspWrongFunc,
    RspShort,
    RspSilent,
    RspFault,
    RspBroadcast
  } rsp_e;

  // mirror of the framer: predicts result words and checks them in order
  class framer_score;
    localparam int MaxShown = 30;

    out_word_t  want_words[$];
    int         errors;
    int         items;
    int         words;
    int         status_seen[8];
    logic [7:0] capacity;
    phase_e     phase;
    logic [15:0] crc;
    logic [8:0] count;
    logic [7:0] addr_want;
    logic [7:0] func_want;
    logic [7:0] exc_code;
    logic       invalid_seen;
    logic       exc_seen;

    function new();
      capacity     = MaxCapacity;
      phase        = PH_IDLE;
      crc          = CrcInit;
      count        = '0;
      addr_want    = '0;
      func_want    = '0;
      exc_code     = '0;
      invalid_seen = 1'b0;
      exc_seen     = 1'b0;
      errors       = 0;
      items        = 0;
      words        = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    // reflected crc-16, one byte lsb first
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
      return r;
    endfunction

    function out_word_t word_of(logic [1:0] kind, logic [7:0] b, logic [7:0] idx,
                                logic [2:0] st, logic [7:0] ev, logic [7:0] pl);
      out_word_t w;
      w.kind            = kind;
      w.out_byte        = b;
      w.store_index     = idx;
      w.status          = st;
      w.exception_value = ev;
      w.payload_length  = pl;
      w.last            = 1'b0;
      return w;
    endfunction

    function void note_item(in_word_t it);
      out_word_t  res[$];
      out_word_t  tail;
      logic [7:0] cap;
      logic [8:0] room;
      logic [8:0] idx;
      logic [8:0] ofs;
      bit         overlong;
      cap      = (capacity > MaxCapacity) ? MaxCapacity : capacity;
      room     = exc_seen ? 9'd1 : {1'b0, cap};
      overlong = 1'b0;
      items++;
      case (it.mode)
        ModeBegin: begin
          addr_want = it.slave_address;
          func_want = it.function_number;
          crc = crc_step(crc_step(CrcInit, it.slave_address), it.function_number);
          phase = PH_TX;
          res.push_back(word_of(KindTx, it.slave_address, 8'd0, StOk, 8'd0, 8'd0));
          res.push_back(word_of(KindTx, it.function_number, 8'd0, StOk, 8'd0, 8'd0));
        end
        ModeParam: begin
          if (phase == PH_TX) begin
            crc = crc_step(crc, it.data_byte);
            res.push_back(word_of(KindTx, it.data_byte, 8'd0, StOk, 8'd0, 8'd0));
          end
        end
        ModeEnd: begin
          if (phase == PH_TX) begin
            res.push_back(word_of(KindTx, crc[7:0], 8'd0, StOk, 8'd0, 8'd0));
            res.push_back(word_of(KindTx, crc[15:8], 8'd0, StOk, 8'd0, 8'd0));
            crc          = CrcInit;
            count        = '0;
            invalid_seen = 1'b0;
            exc_seen     = 1'b0;
            exc_code     = '0;
            if (!it.expect_reply) begin
              // broadcast: nobody answers
              res.push_back(word_of(KindStatus, 8'd0, 8'd0, StTimeout, 8'd0, 8'd0));
              phase = PH_IDLE;
            end else begin
              phase = PH_RX;
            end
          end
        end
        ModeRxByte: begin
          if (phase == PH_RX) begin
            idx = count;
            crc = crc_step(crc, it.data_byte);
            if (idx == 9'd0) begin
              if (it.data_byte != addr_want) invalid_seen = 1'b1;
            end else if (idx == 9'd1) begin
              if (it.data_byte == (func_want | ExceptionMask)) begin
                exc_seen = 1'b1;
              end else if (it.data_byte != func_want) begin
                invalid_seen = 1'b1;
              end
            end else if (idx < 9'd2 + room) begin
              if (exc_seen) begin
                exc_code = it.data_byte;
              end else begin
                ofs = idx - 9'd2;
                res.push_back(word_of(KindStore, it.data_byte, ofs[7:0], StOk, 8'd0, 8'd0));
              end
            end else if (idx > MaxFrameIndex) begin
              // frame too long, give up at once
              res.push_back(word_of(KindStatus, 8'd0, 8'd0, StBadFrame, 8'd0, 8'd0));
              phase    = PH_IDLE;
              overlong = 1'b1;
            end else if (idx >= 9'd4 + room) begin
              invalid_seen = 1'b1;
            end
            if (!overlong) count = idx + 9'd1;
          end
        end
        ModeFrameEnd: begin
          if (phase == PH_RX) begin
            ofs = count - 9'd4;
            if (it.link_fault) begin
              res.push_back(word_of(KindStatus, 8'd0, 8'd0, StLinkFault, 8'd0, 8'd0));
            end else if (count == 9'd0) begin
              res.push_back(word_of(KindStatus, 8'd0, 8'd0, StTimeout, 8'd0, 8'd0));
            end else if (count < 9'd4) begin
              res.push_back(word_of(KindStatus, 8'd0, 8'd0, StBadFrame, 8'd0, 8'd0));
            end else if (crc != 16'h0000) begin
              res.push_back(word_of(KindStatus, 8'd0, 8'd0, StBadCrc, 8'd0, 8'd0));
            end else if (invalid_seen || (exc_seen && count != 9'd5)) begin
              res.push_back(word_of(KindStatus, 8'd0, 8'd0, StInvalid, 8'd0, 8'd0));
            end else if (exc_seen) begin
              res.push_back(word_of(KindStatus, 8'd0, 8'd0, StException, exc_code, 8'd0));
            end else begin
              res.push_back(word_of(KindStatus, 8'd0, 8'd0, StOk, 8'd0, ofs[7:0]));
            end
            phase = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
      // flag the final word of this item
      if (res.size() > 0) begin
        tail      = res.pop_back();
        tail.last = 1'b1;
        res.push_back(tail);
      end
      foreach (res[k]) want_words.push_back(res[k]);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxShown) $display("mismatch: %s", msg);
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got != want) begin
        report($sformatf("word %0d %s got %02h want %02h", words, name, got, want));
      end
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (want_words.size() == 0) begin
        report($sformatf("word with nothing pending, kind %0d byte %02h",
                         got.kind, got.out_byte));
        return;
      end
      want = want_words.pop_front();
      words++;
      if (want.kind == KindStatus) status_seen[want.status]++;
      check_field("kind", {6'd0, got.kind}, {6'd0, want.kind});
      check_field("out_byte", got.out_byte, want.out_byte);
      check_field("store_index", got.store_index, want.store_index);
      check_field("status", {5'd0, got.status}, {5'd0, want.status});
      check_field("exception_value", got.exception_value, want.exception_value);
      check_field("payload_length", got.payload_length, want.payload_length);
      check_field("last", {7'd0, got.last}, {7'd0, want.last});
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  in_word_t   in_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       empty;
  logic       pop;
  out_word_t  out_data;

  framer_score sb;
  bit          idle_on;
  bit          hold_req;
  logic [7:0]  frame_q[$];

  modbus_rtu_master_framer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // item with random filler in the fields this mode ignores
  function automatic in_word_t rand_item(logic [2:0] mode);
    in_word_t    it;
    logic [31:0] r;
    r       = $urandom;
    it      = r[$bits(in_word_t)-1:0];
    it.mode = mode;
    return it;
  endfunction

  // offer one word, wait for it to be taken
  task automatic send_item(input in_word_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    push    = 1'b1;
    in_data = it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_item(it);
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic send_begin(logic [7:0] sa, logic [7:0] fn);
    in_word_t it;
    it                 = rand_item(ModeBegin);
    it.slave_address   = sa;
    it.function_number = fn;
    send_item(it);
  endtask

  task automatic send_data(logic [2:0] mode, logic [7:0] db);
    in_word_t it;
    it           = rand_item(mode);
    it.data_byte = db;
    send_item(it);
  endtask

  task automatic send_end(logic reply);
    in_word_t it;
    it              = rand_item(ModeEnd);
    it.expect_reply = reply;
    send_item(it);
  endtask

  task automatic send_fend(logic fault);
    in_word_t it;
    it            = rand_item(ModeFrameEnd);
    it.link_fault = fault;
    send_item(it);
  endtask

  // words the block ignores in the expected phase; a skipped end leaves it transmitting
  task automatic send_noise(bit in_rx);
    logic [2:0] mode;
    if (in_rx) begin
      mode = 3'($urandom_range(ModeUnusedLo, ModeUnusedHi));
      if ($urandom_range(0, 1)) mode = $urandom_range(0, 1) ? ModeParam : ModeEnd;
    end else begin
      mode = 3'($urandom_range(ModeParam, ModeUnusedHi));
    end
    send_item(rand_item(mode));
  endtask

  // received bytes from frame_q, crc appended when asked
  task automatic send_frame(bit with_crc, bit crc_good);
    logic [15:0] c;
    c = CrcInit;
    foreach (frame_q[k]) c = sb.crc_step(c, frame_q[k]);
    if (!crc_good) c ^= (16'h0001 << $urandom_range(0, 15));
    if (with_crc) begin
      frame_q.push_back(c[7:0]);
      frame_q.push_back(c[15:8]);
    end
    foreach (frame_q[k]) begin
      if ($urandom_range(0, 19) == 0) send_noise(1'b1);
      send_data(ModeRxByte, frame_q[k]);
    end
    frame_q.delete();
  endtask

  // one command and the slave's answer
  task automatic run_transaction(rsp_e kind, int plen);
    logic [7:0] sa;
    logic [7:0] fn;
    bit         skip_end;
    bit         skip_fend;
    sa = 8'($urandom_range(0, 255));
    fn = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 127));
    skip_end  = ($urandom_range(0, 19) == 0);
    skip_fend = ($urandom_range(0, 15) == 0);
    send_begin(sa, fn);
    repeat ($urandom_range(0, 4)) send_data(ModeParam, 8'($urandom_range(0, 255)));
    if (kind == RspBroadcast) begin
      send_end(1'b0);
      return;
    end
    if (!skip_end) send_end(1'b1);
    frame_q.delete();
    case (kind)
      RspException, RspLongExc: begin
        frame_q.push_back(sa);
        frame_q.push_back(fn | ExceptionMask);
        frame_q.push_back(8'($urandom_range(0, 255)));
        if (kind == RspLongExc) begin
          repeat ($urandom_range(1, 2)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        send_frame(1'b1, 1'b1);
      end
      RspShort: begin
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
        send_frame(1'b0, 1'b1);
      end
      RspSilent: begin
      end
      RspFault: begin
        repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
        send_frame(1'b0, 1'b1);
      end
      default: begin
        frame_q.push_back((kind == RspWrongAddr) ? sa ^ 8'($urandom_range(1, 255)) : sa);
        frame_q.push_back((kind == RspWrongFunc) ? fn ^ 8'($urandom_range(1, 127)) : fn);
        repeat (plen) frame_q.push_back(8'($urandom_range(0, 255)));
        send_frame(1'b1, kind != RspBadCrc);
      end
    endcase
    if (!skip_fend) send_fend(kind == RspFault);
  endtask

  task automatic run_random();
    int   r;
    rsp_e kind;
    r = $urandom_range(0, 99);
    if (r < 35)      kind = RspOk;
    else if (r < 50) kind = RspException;
    else if (r < 55) kind = RspLongExc;
    else if (r < 63) kind = RspBadCrc;
    else if (r < 69) kind = RspWrongAddr;
    else if (r < 75) kind = RspWrongFunc;
    else if (r < 81) kind = RspShort;
    else if (r < 86) kind = RspSilent;
    else if (r < 91) kind = RspFault;
    else             kind = RspBroadcast;
    run_transaction(kind, $urandom_range(0, 10));
    if ($urandom_range(0, 7) == 0) send_noise(1'b0);
  endtask

  // wait for every pending word, then let the pipeline go quiet
  task automatic settle();
    while (sb.want_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_capacity(logic [7:0] v);
    settle();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(posedge clk_i);
    sb.capacity = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    bit want_pop;
    int stall_left;
    pop        = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        want_pop = 1'b0;
        stall_left--;
      end else begin
        want_pop = 1'b1;
      end
      pop = want_pop;
      @(posedge clk_i);
      if (pop && !empty) sb.check_word(out_data);
    end
  end

  // stimulus
  initial begin
    int         start;
    logic [7:0] caps[5];
    sb        = new();
    rst_ni    = 1'b0;
    push      = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_on   = 1'b0;
    hold_req  = 1'b0;
    caps[0]   = 8'd0;
    caps[1]   = 8'd255;
    caps[2]   = 8'd3;
    caps[3]   = 8'($urandom_range(4, 251));
    caps[4]   = MaxCapacity;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    idle_on = 1'b1;

    // ignored while idle
    send_data(ModeParam, 8'h5A);
    send_fend(1'b0);
    send_item(rand_item(ModeUnusedHi));
    // extreme bytes, broadcast ends with a timeout
    send_begin(8'hFF, 8'h00);
    send_data(ModeParam, 8'h00);
    send_data(ModeParam, 8'hFF);
    send_end(1'b0);
    // reply expected but no byte comes
    send_begin(8'h00, 8'hFF);
    send_end(1'b1);
    send_data(ModeParam, 8'hA5);
    send_fend(1'b0);
    // exception reply
    send_begin(8'h01, 8'h03);
    send_end(1'b1);
    frame_q.push_back(8'h01);
    frame_q.push_back(8'h83);
    frame_q.push_back(8'h02);
    send_frame(1'b1, 1'b1);
    send_fend(1'b0);
    // port error on frame end
    send_begin(8'h22, 8'h10);
    send_end(1'b1);
    send_data(ModeRxByte, 8'h22);
    send_fend(1'b1);

    // sender pauses for a full drain, then the receiver holds off
    settle();
    hold_req = 1'b1;
    run_transaction(RspOk, 8);
    run_transaction(RspException, 0);

    // random frames over several capacities
    start = sb.items;
    foreach (caps[c]) begin
      set_capacity(caps[c]);
      while (sb.items < start + (c + 1) * RandomItems / 5) run_random();
    end

    // full store and an overlong frame
    run_transaction(RspOk, 252);
    run_transaction(RspOk, 260);

    // last stretch with no idling
    idle_on = 1'b0;
    start   = sb.items;
    while (sb.items < start + QuietItems) run_random();

    settle();
    $display("%0d items accepted, %0d result words checked, capacities 0, 3, %0d, 252, 255",
             sb.items, sb.words, caps[3]);
    $display("status words: ok %0d timeout %0d bad frame %0d bad crc %0d invalid %0d",
             sb.status_seen[StOk], sb.status_seen[StTimeout], sb.status_seen[StBadFrame],
             sb.status_seen[StBadCrc], sb.status_seen[StInvalid]);
    if (sb.errors == 0) begin
      $display("tb_modbus_rtu_master_framer_top: done, clean");
    end else begin
      $display("tb_modbus_rtu_master_framer_top: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RunLimitNs);
    $display("tb_modbus_rtu_master_framer_top: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
hdl/mrm_pkg.sv
hdl/mrm_front.sv
hdl/mrm_cmd_queue.sv
hdl/mrm_back.sv
hdl/modbus_rtu_master_framer_top.sv
tb/tb_modbus_rtu_master_framer_top.sv
